FILE: design/i2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types, codes and glyph helpers of the integer to ascii formatter
// ----------------------------------------------------------------------------
package i2a_pkg;

    // sizes
    localparam int DIGIT_BUFFER_DEF = 24;
    localparam int QUEUE_DEPTH      = 2;
    localparam int VALUE_W          = 64;
    localparam int PAD_W            = 6;
    localparam int CHAR_W           = 7;
    localparam int BCD_DIGITS       = 20;
    localparam int BCD_W            = BCD_DIGITS * 4;
    localparam int DD_W             = BCD_W + VALUE_W;
    localparam int DD_BITS_PER_STEP = 4;
    localparam int BCD_STEPS        = VALUE_W / DD_BITS_PER_STEP;
    localparam int STEP_W           = $clog2(BCD_STEPS);

    // command codes
    localparam logic [2:0] CMD_SDEC   = 3'd0;
    localparam logic [2:0] CMD_UDEC   = 3'd1;
    localparam logic [2:0] CMD_HEX_UP = 3'd2;
    localparam logic [2:0] CMD_HEX_LO = 3'd3;
    localparam logic [2:0] CMD_OCT    = 3'd4;
    localparam logic [2:0] CMD_PTR    = 3'd5;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_X      = 7'h78;
    localparam logic [CHAR_W-1:0] CH_ALPHA  = 7'h37;
    localparam logic [CHAR_W-1:0] LOWER_BIT = 7'h20;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_OCT
    } radix_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX
    } prefix_t;

    typedef struct packed {
        radix_t              radix;
        logic                lower;
        prefix_t             prefix;
        logic [PAD_W-1:0]    pad_width;
        logic [VALUE_W-1:0]  mag;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BCD,
        ST_SPLIT,
        ST_PREFIX,
        ST_PAD,
        ST_DIGIT
    } back_state_t;

    // glyph of one digit, letters folded to lower case on request
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic lower);
        logic [CHAR_W-1:0] ch;
        if (d < 4'd10)
        begin
            ch = CH_ZERO + {3'b000, d};
        end
        else
        begin
            ch = (CH_ALPHA + {3'b000, d}) | (lower ? LOWER_BIT : '0);
        end
        return ch;
    endfunction

    function automatic logic [1:0] prefix_len(input prefix_t p);
        logic [1:0] n;
        case (p)
            PFX_MINUS: n = 2'd1;
            PFX_HEX:   n = 2'd2;
            default:   n = 2'd0;
        endcase
        return n;
    endfunction

endpackage : i2a_pkg
`default_nettype wire

FILE: design/integer_to_ascii_formatter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// zero-padded printf-style integer to ascii conversion, one character per item
// ----------------------------------------------------------------------------
// Each input item (command, value, pad_width) produces max(pad_width, natural
// length) output items of one ascii character each, most significant first,
// with last set on the final one; commands 6 and 7 are taken and produce
// nothing. An item is taken from the job queue, converted from binary to bcd
// (four bits a cycle) for the decimal kinds, split one digit per cycle onto
// the digit stack, and then sent one character per cycle through the output
// register whenever out_stall does not hold it. The two-entry job queue lets
// up to two decoded items wait while the formatter is busy.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
    parameter int DIGIT_BUFFER = i2a_pkg::DIGIT_BUFFER_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input items
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [2:0]                  command,
    input  wire logic [i2a_pkg::VALUE_W-1:0] value,
    input  wire logic [i2a_pkg::PAD_W-1:0]   pad_width,
    // result items
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [i2a_pkg::CHAR_W-1:0]       character,
    output logic                             last
);
    import i2a_pkg::*;

    // front to queue
    logic q_push;
    job_t q_push_job;
    logic q_full;
    // queue to back
    logic q_pop;
    logic q_not_empty;
    job_t q_head;

    // decode command, take sign and magnitude
    i2a_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .pad_width (pad_width),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_push_job)
    );

    // decoded jobs wait here so the input side keeps moving
    i2a_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (q_head)
    );

    // digit conversion and character sequencing
    i2a_back #(
        .DIGIT_BUFFER (DIGIT_BUFFER)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

endmodule : integer_to_ascii_formatter_unit
`default_nettype wire

FILE: design/i2a_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_front
// accepts items, decodes the conversion kind and takes the magnitude
// ----------------------------------------------------------------------------
module i2a_front (
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [2:0]                  command,
    input  wire logic [i2a_pkg::VALUE_W-1:0] value,
    input  wire logic [i2a_pkg::PAD_W-1:0]   pad_width,
    input  wire logic                        q_full,
    output logic                             q_push,
    output i2a_pkg::job_t                    q_job
);
    import i2a_pkg::*;

    logic known;

    assign in_stall = q_full;

    always_comb
    begin
        known           = 1'b1;
        q_job.radix     = RADIX_DEC;
        q_job.lower     = 1'b0;
        q_job.prefix    = PFX_NONE;
        q_job.pad_width = pad_width;
        q_job.mag       = value;
        case (command)
            CMD_SDEC:
            begin
                if (value[VALUE_W-1])
                begin
                    q_job.prefix = PFX_MINUS;
                    q_job.mag    = '0 - value;
                end
            end
            CMD_UDEC:   q_job.radix = RADIX_DEC;
            CMD_HEX_UP: q_job.radix = RADIX_HEX;
            CMD_HEX_LO:
            begin
                q_job.radix = RADIX_HEX;
                q_job.lower = 1'b1;
            end
            CMD_OCT:    q_job.radix = RADIX_OCT;
            CMD_PTR:
            begin
                q_job.radix  = RADIX_HEX;
                q_job.lower  = 1'b1;
                q_job.prefix = PFX_HEX;
            end
            default:    known = 1'b0;  // unknown kinds are taken and dropped
        endcase
    end

    assign q_push = in_valid && !q_full && known;

endmodule : i2a_front
`default_nettype wire

FILE: design/i2a_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_queue
// short job queue between the decoding front and the formatting back
// ----------------------------------------------------------------------------
module i2a_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire i2a_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output i2a_pkg::job_t      head_job
);
    import i2a_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    push_when_full_a: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job pushed into a full queue");

    pop_when_empty_a: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("job popped from an empty queue");

    count_track_a: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count lost a push");

endmodule : i2a_queue
`default_nettype wire

FILE: design/i2a_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_back
// digit conversion, digit stack and character sequencer with output register
// ----------------------------------------------------------------------------
module i2a_back #(
    parameter int DIGIT_BUFFER = i2a_pkg::DIGIT_BUFFER_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_not_empty,
    input  wire i2a_pkg::job_t              q_head,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [i2a_pkg::CHAR_W-1:0]      character,
    output logic                            last
);
    import i2a_pkg::*;

    localparam int CW = $clog2(DIGIT_BUFFER + 1);
    localparam int TW = CW + 2;

    back_state_t         state_reg, state_next;
    radix_t              radix_reg, radix_next;
    logic                lower_reg, lower_next;
    prefix_t             prefix_reg, prefix_next;
    logic [PAD_W-1:0]    width_reg, width_next;
    logic [PAD_W-1:0]    pad_reg, pad_next;
    logic                pi_reg, pi_next;
    logic [BCD_W-1:0]    work_reg, work_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CW-1:0]       nd_reg, nd_next;
    logic [3:0]          digit_reg [DIGIT_BUFFER];
    logic [3:0]          digit_next [DIGIT_BUFFER];
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                out_load;
    logic [CHAR_W-1:0]   out_char;
    logic                out_last;
    logic [DD_W-1:0]     dd_out;
    logic [3:0]          split_digit;
    logic [BCD_W-1:0]    split_rest;
    logic [CW-1:0]       nd_inc;
    logic [TW-1:0]       total_len;
    logic [PAD_W-1:0]    pad_calc;

    // four shift-and-adjust steps of the binary to bcd conversion
    function automatic logic [DD_W-1:0] dabble4(input logic [DD_W-1:0] x);
        logic [DD_W-1:0] t;
        t = x;
        for (int s = 0; s < DD_BITS_PER_STEP; s++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                if (t[VALUE_W + 4*k +: 4] >= 4'd5)
                begin
                    t[VALUE_W + 4*k +: 4] = t[VALUE_W + 4*k +: 4] + 4'd3;
                end
            end
            t = {t[DD_W-2:0], 1'b0};
        end
        return t;
    endfunction

    assign dd_out      = dabble4({work_reg, bin_reg});
    assign split_digit = (radix_reg == RADIX_OCT) ? {1'b0, work_reg[2:0]} : work_reg[3:0];
    assign split_rest  = (radix_reg == RADIX_OCT) ? (work_reg >> 3) : (work_reg >> 4);
    assign nd_inc      = nd_reg + 1'b1;
    assign total_len   = TW'(prefix_len(prefix_reg)) + TW'(nd_inc);
    assign pad_calc    = (TW'(width_reg) > total_len) ? PAD_W'(TW'(width_reg) - total_len) : '0;
    assign out_free    = !valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        radix_next  = radix_reg;
        lower_next  = lower_reg;
        prefix_next = prefix_reg;
        width_next  = width_reg;
        pad_next    = pad_reg;
        pi_next     = pi_reg;
        work_next   = work_reg;
        bin_next    = bin_reg;
        step_next   = step_reg;
        nd_next     = nd_reg;
        digit_next  = digit_reg;
        q_pop       = 1'b0;
        out_load    = 1'b0;
        out_char    = CH_ZERO;
        out_last    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop       = 1'b1;
                    radix_next  = q_head.radix;
                    lower_next  = q_head.lower;
                    prefix_next = q_head.prefix;
                    width_next  = q_head.pad_width;
                    pi_next     = 1'b0;
                    nd_next     = '0;
                    step_next   = '0;
                    if (q_head.radix == RADIX_DEC)
                    begin
                        bin_next   = q_head.mag;
                        work_next  = '0;
                        state_next = ST_BCD;
                    end
                    else
                    begin
                        work_next  = BCD_W'(q_head.mag);
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_BCD:
            begin
                {work_next, bin_next} = dd_out;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(BCD_STEPS - 1))
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                // digits come least significant first and stack up
                digit_next[0] = split_digit;
                for (int i = 1; i < DIGIT_BUFFER; i++)
                begin
                    digit_next[i] = digit_reg[i-1];
                end
                work_next = split_rest;
                nd_next   = nd_inc;
                if ((split_rest == '0) || (nd_inc >= CW'(DIGIT_BUFFER)))
                begin
                    pad_next = pad_calc;
                    if (prefix_reg != PFX_NONE)
                    begin
                        state_next = ST_PREFIX;
                    end
                    else if (pad_calc != '0)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_PREFIX:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (prefix_reg == PFX_MINUS)
                    begin
                        out_char = CH_MINUS;
                    end
                    else
                    begin
                        out_char = pi_reg ? CH_X : CH_ZERO;
                    end
                    if ((prefix_reg == PFX_MINUS) || pi_reg)
                    begin
                        state_next = (pad_reg != '0) ? ST_PAD : ST_DIGIT;
                    end
                    else
                    begin
                        pi_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_char = CH_ZERO;
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == PAD_W'(1))
                    begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_char = digit_char(digit_reg[0], lower_reg);
                    out_last = (nd_reg == CW'(1));
                    for (int i = 0; i < DIGIT_BUFFER - 1; i++)
                    begin
                        digit_next[i] = digit_reg[i+1];
                    end
                    digit_next[DIGIT_BUFFER-1] = 4'd0;
                    nd_next = nd_reg - 1'b1;
                    if (nd_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (out_load)
        begin
            valid_next = 1'b1;
            char_next  = out_char;
            last_next  = out_last;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            nd_reg    <= '0;
            pad_reg   <= '0;
            pi_reg    <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            nd_reg    <= nd_next;
            pad_reg   <= pad_next;
            pi_reg    <= pi_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg  <= radix_next;
        lower_reg  <= lower_next;
        prefix_reg <= prefix_next;
        width_reg  <= width_next;
        work_reg   <= work_next;
        bin_reg    <= bin_next;
        digit_reg  <= digit_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign out_valid = valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    digit_stack_nonempty_a: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (nd_reg != '0))
        else $error("digit phase entered with an empty digit stack");

    last_ends_item_a: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer still busy after the last character");

    bcd_length_a: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BCD && step_reg == STEP_W'(BCD_STEPS - 1)) |=> (state_reg == ST_SPLIT))
        else $error("bcd conversion did not finish on time");

    no_load_while_held_a: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |-> !out_load)
        else $error("output register overwritten while stalled");

endmodule : i2a_back
`default_nettype wire
